[sv/fcs_pkg.sv]
// Shared types, address codes and ring helpers for the FAST-9 corner score block.
`default_nettype none
package fcs_pkg;

  localparam int RING_LEN   = 16;
  localparam int PIX_W      = 8;
  localparam int ARC_LEN    = 9;
  localparam int SEARCH_STEPS = 8;
  localparam logic [ARC_LEN-1:0] ARC_MASK = 9'h1FF;
  localparam logic [PIX_W-1:0]   MAX_LEVEL = 8'd255;

  // Configuration register select (paddr bit 2)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  localparam logic [7:0] THRESHOLD_RST = 8'd10;
  localparam logic       MODE_RST      = 1'b1;

  typedef struct packed {
    logic [7:0]  center_pixel;
    logic [63:0] ring_first_half;
    logic [63:0] ring_second_half;
  } in_req_t;

  typedef struct packed {
    logic       is_corner;
    logic [7:0] strength;
  } out_res_t;

  // Per-item state carried through the search pipeline
  typedef struct packed {
    logic [7:0]   c;
    logic [127:0] ring;   // pixel k in bits 8k+7:8k
    logic [7:0]   ad0;
    logic [7:0]   ad4;
    logic [7:0]   ad8;
    logic [7:0]   ad12;
    logic [7:0]   lo_p;
    logic [7:0]   hi_p;
    logic [7:0]   lo_n;
    logic [7:0]   hi_n;
    logic         pos;
    logic         neg;
    logic         corner;
  } stage_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // True when any 9 circularly contiguous bits are set
  function automatic logic has_arc(input logic [RING_LEN-1:0] mask);
    logic [2*RING_LEN-1:0] dbl;
    logic hit;
    dbl = {mask, mask};
    hit = 1'b0;
    for (int i = 0; i < RING_LEN; i++) begin
      if (dbl[i +: ARC_LEN] == ARC_MASK) hit = 1'b1;
    end
    has_arc = hit;
  endfunction

  // Early reject against a trial threshold
  function automatic logic rejected(input stage_t s, input logic [7:0] t);
    rejected = ((s.ad0 < t) && (s.ad8 < t)) || ((s.ad4 < t) && (s.ad12 < t));
  endfunction

  // Brighter mask: p > c + t
  function automatic logic [RING_LEN-1:0] bright_mask(input logic [127:0] ring,
                                                       input logic [7:0] c,
                                                       input logic [7:0] t);
    logic [RING_LEN-1:0] m;
    logic [8:0] lim;
    lim = {1'b0, c} + {1'b0, t};
    for (int i = 0; i < RING_LEN; i++) begin
      m[i] = {1'b0, ring[PIX_W*i +: PIX_W]} > lim;
    end
    bright_mask = m;
  endfunction

  // Darker mask: p < c - t, written as p + t < c
  function automatic logic [RING_LEN-1:0] dark_mask(input logic [127:0] ring,
                                                     input logic [7:0] c,
                                                     input logic [7:0] t);
    logic [RING_LEN-1:0] m;
    for (int i = 0; i < RING_LEN; i++) begin
      m[i] = ({1'b0, ring[PIX_W*i +: PIX_W]} + {1'b0, t}) < {1'b0, c};
    end
    dark_mask = m;
  endfunction

endpackage
`default_nettype wire

[sv/fcs_step.sv]
// One registered step of the per-polarity threshold binary search.
`default_nettype none
module fcs_step
  import fcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   vld_in,
  input  wire stage_t st_in,
  output logic        vld_out,
  output stage_t      st_out
);

  logic   vld_r;
  stage_t st_r;
  stage_t st_nxt;
  logic [7:0] mid_p;
  logic [7:0] mid_n;
  logic [8:0] sum_p;
  logic [8:0] sum_n;
  logic       pass_p;
  logic       pass_n;

  // Midpoints of each polarity's open interval
  always_comb begin
    sum_p = {1'b0, st_in.hi_p} + {1'b0, st_in.lo_p};
    sum_n = {1'b0, st_in.hi_n} + {1'b0, st_in.lo_n};
    mid_p = sum_p[8:1];
    mid_n = sum_n[8:1];
  end

  // Trial tests at the midpoints
  always_comb begin
    pass_p = !rejected(st_in, mid_p) && has_arc(bright_mask(st_in.ring, st_in.c, mid_p));
    pass_n = !rejected(st_in, mid_n) && has_arc(dark_mask(st_in.ring, st_in.c, mid_n));
  end

  // Narrow intervals still wider than one
  always_comb begin
    st_nxt = st_in;
    if ((st_in.hi_p - st_in.lo_p) > 8'd1) begin
      if (pass_p) st_nxt.lo_p = mid_p;
      else        st_nxt.hi_p = mid_p;
    end
    if ((st_in.hi_n - st_in.lo_n) > 8'd1) begin
      if (pass_n) st_nxt.lo_n = mid_n;
      else        st_nxt.hi_n = mid_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_in;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;

endmodule
`default_nettype wire

[sv/fast9_corner_score.sv]
// Top level: FAST-9 corner test and binary-search corner score, fully pipelined.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  ----------------------------
//  input     start, busy, in_req                          taken when start & !busy
//  result    out_strobe, out_res                          one cycle per request
//  config    cfg_psel/penable/pwrite/paddr/pwdata/prdata  APB write in access cycle
//            cfg_pready
//
// One request enters every cycle; busy stays low. Each result passes through eleven
// register stages: input/abs-diff stage, threshold test stage, eight binary search
// stages (one halving per stage) and the output register.
// Synchronous active-low reset clears the valid bits and sets threshold 10 and
// strength mode. The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module fast9_corner_score
  import fcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  output logic             out_strobe,
  output out_res_t         out_res,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0] threshold_r;
  logic       mode_r;
  logic       cfg_wr;

  logic         s1_vld_r;
  logic [7:0]   s1_c_r;
  logic [127:0] s1_ring_r;
  logic [7:0]   s1_ad0_r;
  logic [7:0]   s1_ad4_r;
  logic [7:0]   s1_ad8_r;
  logic [7:0]   s1_ad12_r;

  stage_t s2_nxt;
  stage_t st [0:SEARCH_STEPS];
  logic   vld [0:SEARCH_STEPS];
  logic   s2_vld_r;
  stage_t s2_r;

  logic       out_strobe_r;
  out_res_t   out_res_r;
  out_res_t   out_res_nxt;
  logic [7:0] sp;
  logic [7:0] sn;

  // Configuration registers
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      mode_r      <= MODE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_THRESHOLD: threshold_r <= cfg_pwdata[7:0];
        REG_MODE:      mode_r      <= cfg_pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_THRESHOLD: cfg_prdata = {24'd0, threshold_r};
      REG_MODE:      cfg_prdata = {31'd0, mode_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign busy       = 1'b0;

  // Stage 1: capture request and opposite-pixel differences
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_c_r    <= in_req.center_pixel;
    s1_ring_r <= {in_req.ring_second_half, in_req.ring_first_half};
    s1_ad0_r  <= absdiff(in_req.center_pixel, in_req.ring_first_half[7:0]);
    s1_ad4_r  <= absdiff(in_req.center_pixel, in_req.ring_first_half[39:32]);
    s1_ad8_r  <= absdiff(in_req.center_pixel, in_req.ring_second_half[7:0]);
    s1_ad12_r <= absdiff(in_req.center_pixel, in_req.ring_second_half[39:32]);
  end

  // Stage 2: test at the configured threshold, open search intervals
  always_comb begin
    s2_nxt.c      = s1_c_r;
    s2_nxt.ring   = s1_ring_r;
    s2_nxt.ad0    = s1_ad0_r;
    s2_nxt.ad4    = s1_ad4_r;
    s2_nxt.ad8    = s1_ad8_r;
    s2_nxt.ad12   = s1_ad12_r;
    s2_nxt.lo_p   = threshold_r;
    s2_nxt.hi_p   = MAX_LEVEL;
    s2_nxt.lo_n   = threshold_r;
    s2_nxt.hi_n   = MAX_LEVEL;
    s2_nxt.pos    = has_arc(bright_mask(s1_ring_r, s1_c_r, threshold_r));
    s2_nxt.neg    = has_arc(dark_mask(s1_ring_r, s1_c_r, threshold_r));
    s2_nxt.corner = 1'b0;
    s2_nxt.corner = !rejected(s2_nxt, threshold_r) && (s2_nxt.pos || s2_nxt.neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign st[0]  = s2_r;
  assign vld[0] = s2_vld_r;

  // Search stages
  for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_step
    fcs_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld[g]),
      .st_in   (st[g]),
      .vld_out (vld[g+1]),
      .st_out  (st[g+1])
    );
  end

  // Output: zero strength for a non-corner, else the larger polarity score, or the threshold in detect mode
  always_comb begin
    sp = st[SEARCH_STEPS].pos ? st[SEARCH_STEPS].lo_p : 8'd0;
    sn = st[SEARCH_STEPS].neg ? st[SEARCH_STEPS].lo_n : 8'd0;
    out_res_nxt.is_corner = st[SEARCH_STEPS].corner;
    if (!st[SEARCH_STEPS].corner) out_res_nxt.strength = 8'd0;
    else if (mode_r)              out_res_nxt.strength = (sp > sn) ? sp : sn;
    else                          out_res_nxt.strength = threshold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= vld[SEARCH_STEPS];
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire
